// ===== rtl/core/pj2s_pkg.sv =====
// ----------------------------------------------------------------------------
// pj2s_pkg: shared types and constants for the perspective projection unit
// Field widths, divider geometry, register indexes and one-step helpers.
// ----------------------------------------------------------------------------
package pj2s_pkg;

	// Field and register widths
	localparam int COORD_BITS  = 16;
	localparam int EYE_BITS    = 16;
	localparam int CENTRE_BITS = 12;
	localparam int CFG_DATA_BITS = 16;

	// Signed product x*e, its magnitude, the signed divisor and its magnitude
	localparam int PROD_BITS = COORD_BITS + EYE_BITS + 1;
	localparam int NUM_BITS  = COORD_BITS + EYE_BITS - 1;
	localparam int DEN_BITS  = ((COORD_BITS > EYE_BITS) ? COORD_BITS : EYE_BITS) + 2;
	localparam int DIV_BITS  = DEN_BITS - 1;
	localparam int SUM_BITS  = NUM_BITS + 2;

	// Start transfer to result strobe, in clock cycles
	localparam int LATENCY = NUM_BITS + 3;

	// Register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_EYE_DISTANCE = 2'd0;
	localparam cfg_idx_t REG_CENTER_X     = 2'd1;
	localparam cfg_idx_t REG_CENTER_Y     = 2'd2;

	// Register reset values
	localparam logic [EYE_BITS-1:0]    EYE_RESET      = 16'd1000;
	localparam logic [CENTRE_BITS-1:0] CENTER_X_RESET = 12'd160;
	localparam logic [CENTRE_BITS-1:0] CENTER_Y_RESET = 12'd120;

	// Port payloads
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
		logic signed [COORD_BITS-1:0] z_coord;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] screen_u;
		logic signed [COORD_BITS-1:0] screen_v;
		logic                         overflow;
		logic                         div_zero;
	} pixel_t;

	// Configuration snapshot
	typedef struct packed {
		logic [EYE_BITS-1:0]    eye_distance;
		logic [CENTRE_BITS-1:0] center_x;
		logic [CENTRE_BITS-1:0] center_y;
	} proj_cfg_t;

	// Sideband that rides alongside the divider
	typedef struct packed {
		logic neg_u;
		logic neg_v;
		logic div_zero;
	} side_t;

	// One divider lane: partial remainder, and numerator bits shifting out
	// at the top while quotient bits shift in at the bottom
	typedef struct packed {
		logic [DIV_BITS-1:0] rem;
		logic [NUM_BITS-1:0] nq;
	} div_lane_t;

	typedef struct packed {
		div_lane_t           u;
		div_lane_t           v;
		logic [DIV_BITS-1:0] divisor;
		side_t               side;
	} div_stage_t;

	typedef struct packed {
		logic [NUM_BITS-1:0] quot_u;
		logic [NUM_BITS-1:0] quot_v;
		side_t               side;
	} div_res_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] val;
		logic                         ovf;
	} sat_t;

	// One restoring division step
	function automatic div_lane_t div_step(div_lane_t cur, logic [DIV_BITS-1:0] d);
		logic [DIV_BITS:0] trial;
		logic [DIV_BITS:0] diff;
		logic              ge;
		div_lane_t         nxt;
		trial = {cur.rem, cur.nq[NUM_BITS-1]};
		diff  = trial - {1'b0, d};
		ge    = (trial >= {1'b0, d});
		nxt.rem = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
		nxt.nq  = {cur.nq[NUM_BITS-2:0], ge};
		return nxt;
	endfunction

	// Clamp a wide signed sum to the coordinate range
	function automatic sat_t saturate(logic signed [SUM_BITS-1:0] s);
		logic signed [SUM_BITS-1:0] hi;
		logic signed [SUM_BITS-1:0] lo;
		sat_t                       r;
		hi = {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
		lo = {{(SUM_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
		if (s > hi) begin
			r.val = hi[COORD_BITS-1:0];
			r.ovf = 1'b1;
		end else if (s < lo) begin
			r.val = lo[COORD_BITS-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = s[COORD_BITS-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/perspective_project_to_screen_unit.sv =====
// ----------------------------------------------------------------------------
// perspective_project_to_screen_unit: vertex to screen pixel projection
// u = cx + x*e/(e-z), v = cy - y*e/(e-z), quotient truncated, saturated.
// ----------------------------------------------------------------------------
// Takes one vertex per clock and never stalls: busy is high only in the
// first cycle after reset. Every vertex transferred on start gives exactly
// one result, marked by result_valid for one cycle. A vertex passes the
// product stage, the sign/magnitude stage, the divider, which resolves one
// quotient bit per pipeline stage, and the centre/saturation stage in turn.
// There is no back-pressure: the receiver must take every result when it is
// shown. Configuration writes are always accepted and should only be issued
// while no vertex is in flight.
// ----------------------------------------------------------------------------
module perspective_project_to_screen_unit
	import pj2s_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// Vertex command
	input  logic                     start,
	output logic                     busy,
	input  vertex_t                  vertex,
	// Result
	output logic                     result_valid,
	output pixel_t                   result,
	// Register writes
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  cfg_idx_t                 cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	proj_cfg_t  cfg_q;
	logic       busy_q;
	logic       front_valid;
	div_stage_t front_stage;
	logic       div_valid;
	div_res_t   div_res;

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;

	// Hold off transfers for one cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eye_distance <= EYE_RESET;
			cfg_q.center_x     <= CENTER_X_RESET;
			cfg_q.center_y     <= CENTER_Y_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EYE_DISTANCE: cfg_q.eye_distance <= cfg_data[EYE_BITS-1:0];
				REG_CENTER_X:     cfg_q.center_x     <= cfg_data[CENTRE_BITS-1:0];
				REG_CENTER_Y:     cfg_q.center_y     <= cfg_data[CENTRE_BITS-1:0];
				default:          ;
			endcase
		end
	end

	pj2s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy_q),
		.vertex    (vertex),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_stage (front_stage)
	);

	pj2s_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_stage  (front_stage),
		.out_valid (div_valid),
		.out_res   (div_res)
	);

	pj2s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_res    (div_res),
		.cfg       (cfg_q),
		.out_valid (result_valid),
		.out_pixel (result)
	);

endmodule

// ===== rtl/core/pj2s_front.sv =====
// ----------------------------------------------------------------------------
// pj2s_front: product and divisor stages
// Stage 1 forms x*e, y*e and e-z; stage 2 splits them into sign and magnitude.
// ----------------------------------------------------------------------------
module pj2s_front
	import pj2s_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  vertex_t    vertex,
	input  proj_cfg_t  cfg,
	output logic       out_valid,
	output div_stage_t out_stage
);

	logic signed [PROD_BITS-1:0] prod_u_s1;
	logic signed [PROD_BITS-1:0] prod_v_s1;
	logic signed [DEN_BITS-1:0]  den_s1;
	logic                        valid_s1;
	logic signed [PROD_BITS-1:0] eye_ext;
	logic signed [DEN_BITS-1:0]  eye_den;
	logic signed [DEN_BITS-1:0]  z_den;
	logic signed [PROD_BITS-1:0] mag_u;
	logic signed [PROD_BITS-1:0] mag_v;
	logic signed [DEN_BITS-1:0]  mag_d;

	assign eye_ext = $signed({{(PROD_BITS-EYE_BITS){1'b0}}, cfg.eye_distance});
	assign eye_den = $signed({{(DEN_BITS-EYE_BITS){1'b0}}, cfg.eye_distance});
	assign z_den   = DEN_BITS'(vertex.z_coord);

	// Stage 1: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1: products and denominator
	always_ff @(posedge clk) begin
		prod_u_s1 <= PROD_BITS'(vertex.x_coord) * eye_ext;
		prod_v_s1 <= PROD_BITS'(vertex.y_coord) * eye_ext;
		den_s1    <= eye_den - z_den;
	end

	// Magnitudes
	assign mag_u = prod_u_s1[PROD_BITS-1] ? -prod_u_s1 : prod_u_s1;
	assign mag_v = prod_v_s1[PROD_BITS-1] ? -prod_v_s1 : prod_v_s1;
	assign mag_d = den_s1[DEN_BITS-1] ? -den_s1 : den_s1;

	// Stage 2: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s1;
		end
	end

	// Stage 2: sign and magnitude, divider seed
	always_ff @(posedge clk) begin
		out_stage.u.rem         <= '0;
		out_stage.u.nq          <= mag_u[NUM_BITS-1:0];
		out_stage.v.rem         <= '0;
		out_stage.v.nq          <= mag_v[NUM_BITS-1:0];
		out_stage.divisor       <= mag_d[DIV_BITS-1:0];
		out_stage.side.neg_u    <= prod_u_s1[PROD_BITS-1] ^ den_s1[DEN_BITS-1];
		out_stage.side.neg_v    <= prod_v_s1[PROD_BITS-1] ^ den_s1[DEN_BITS-1];
		out_stage.side.div_zero <= (den_s1 == '0);
	end

endmodule

// ===== rtl/core/pj2s_divider.sv =====
// ----------------------------------------------------------------------------
// pj2s_divider: pipelined restoring divider, two lanes on a shared divisor
// One quotient bit per stage, NUM_BITS stages, one new pair every cycle.
// ----------------------------------------------------------------------------
module pj2s_divider
	import pj2s_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  div_stage_t in_stage,
	output logic       out_valid,
	output div_res_t   out_res
);

	div_stage_t stage_s [0:NUM_BITS];
	logic       valid_s [0:NUM_BITS];

	assign stage_s[0] = in_stage;
	assign valid_s[0] = in_valid;

	for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
		// Valid travels with the stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		// One quotient bit for each lane
		always_ff @(posedge clk) begin
			stage_s[k+1].u       <= div_step(stage_s[k].u, stage_s[k].divisor);
			stage_s[k+1].v       <= div_step(stage_s[k].v, stage_s[k].divisor);
			stage_s[k+1].divisor <= stage_s[k].divisor;
			stage_s[k+1].side    <= stage_s[k].side;
		end
	end

	assign out_valid      = valid_s[NUM_BITS];
	assign out_res.quot_u = stage_s[NUM_BITS].u.nq;
	assign out_res.quot_v = stage_s[NUM_BITS].v.nq;
	assign out_res.side   = stage_s[NUM_BITS].side;

endmodule

// ===== rtl/core/pj2s_back.sv =====
// ----------------------------------------------------------------------------
// pj2s_back: sign, centre offset and saturation
// Final register stage; drives the result strobe and payload.
// ----------------------------------------------------------------------------
module pj2s_back
	import pj2s_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_res_t  in_res,
	input  proj_cfg_t cfg,
	output logic      out_valid,
	output pixel_t    out_pixel
);

	logic signed [NUM_BITS:0]   sq_u;
	logic signed [NUM_BITS:0]   sq_v;
	logic signed [SUM_BITS-1:0] cx;
	logic signed [SUM_BITS-1:0] cy;
	logic signed [SUM_BITS-1:0] sum_u;
	logic signed [SUM_BITS-1:0] sum_v;
	sat_t                       sat_u;
	sat_t                       sat_v;

	// Signed quotients, truncated toward zero
	assign sq_u = in_res.side.neg_u ? -$signed({1'b0, in_res.quot_u})
	                                :  $signed({1'b0, in_res.quot_u});
	assign sq_v = in_res.side.neg_v ? -$signed({1'b0, in_res.quot_v})
	                                :  $signed({1'b0, in_res.quot_v});

	// Move to window centre, Y flipped
	assign cx    = $signed({{(SUM_BITS-CENTRE_BITS){1'b0}}, cfg.center_x});
	assign cy    = $signed({{(SUM_BITS-CENTRE_BITS){1'b0}}, cfg.center_y});
	assign sum_u = cx + SUM_BITS'(sq_u);
	assign sum_v = cy - SUM_BITS'(sq_v);
	assign sat_u = saturate(sum_u);
	assign sat_v = saturate(sum_v);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// Result payload; a zero divisor forces zero coordinates
	always_ff @(posedge clk) begin
		if (in_res.side.div_zero) begin
			out_pixel.screen_u <= '0;
			out_pixel.screen_v <= '0;
			out_pixel.overflow <= 1'b0;
			out_pixel.div_zero <= 1'b1;
		end else begin
			out_pixel.screen_u <= sat_u.val;
			out_pixel.screen_v <= sat_v.val;
			out_pixel.overflow <= sat_u.ovf | sat_v.ovf;
			out_pixel.div_zero <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/pj2s_checker.sv =====
// ----------------------------------------------------------------------------
// pj2s_props: port-level checks for the projection unit
// Fixed latency, one result per vertex, and consistency of the result flags.
// ----------------------------------------------------------------------------
module pj2s_props
	import pj2s_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input pixel_t  result
);

	// Every transfer yields a result after the pipeline latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY result_valid)
		else $error("result missing after vertex transfer");

	// No result without a matching transfer one pipeline latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LATENCY))
		else $error("result without matching vertex transfer");

	// Zero divisor gives zero coordinates and no overflow
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.div_zero) |->
			(result.screen_u == '0 && result.screen_v == '0 && !result.overflow))
		else $error("division by zero result not cleared");

	// Overflow means at least one coordinate sits at a range end
	a_overflow_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow) |->
			(result.screen_u == {1'b0, {(COORD_BITS-1){1'b1}}} ||
			 result.screen_u == {1'b1, {(COORD_BITS-1){1'b0}}} ||
			 result.screen_v == {1'b0, {(COORD_BITS-1){1'b1}}} ||
			 result.screen_v == {1'b1, {(COORD_BITS-1){1'b0}}}))
		else $error("overflow flagged without a clamped coordinate");

endmodule

bind perspective_project_to_screen_unit pj2s_props u_pj2s_props (.*);
